[hdl/ofa_pkg.sv]
package ofa_pkg;

    // Fixed-point limits and reset values.
    localparam logic [62:0] MAX63      = {63{1'b1}};
    localparam logic [31:0] MAX32      = {32{1'b1}};
    localparam logic [62:0] CASH_RESET = 63'd65536000000;
    localparam logic [31:0] MARK_RESET = 32'd640000;

    // Width of the divider's quotient and divisor.
    localparam int unsigned DIV_W = 32;

    // Status that the divider reports to its sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Add a 64-bit value to a 63-bit one, saturating at 2^63-1.
    function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [63:0] b);
        logic [64:0] sum;
        sum = {2'b00, a} + {1'b0, b};
        if (sum > {2'b00, MAX63}) begin
            return MAX63;
        end
        return sum[62:0];
    endfunction

endpackage

[hdl/ofa_div.sv]
module ofa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [62:0]                 i_dividend,
    input  logic [ofa_pkg::DIV_W-1:0]   i_divisor,
    output logic [ofa_pkg::DIV_W-1:0]   o_quotient,
    output ofa_pkg::t_div_stat          o_stat
);
    import ofa_pkg::*;

    // Restoring divider, one quotient bit per cycle. The caller guarantees
    // that the upper dividend bits are below the divisor, so the quotient
    // fits in DIV_W bits.
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_low;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   trial;
    logic             fits;

    // One shift-subtract step.
    always_comb begin
        trial = {r_rem, r_low[DIV_W-1]};
        fits  = trial >= {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {1'b0, i_dividend[62:DIV_W]};
                r_low  <= i_dividend[DIV_W-1:0];
                r_cnt  <= 5'(DIV_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= DIV_W'(trial - {1'b0, i_divisor});
                end else begin
                    r_rem <= trial[DIV_W-1:0];
                end
                // Quotient bits shift in as dividend bits shift out.
                r_low <= {r_low[DIV_W-2:0], fits};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_quotient  = r_low;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[hdl/order_fill_accounting_unit.sv]
// Sequence: a begin or an ignored entry passes S_IDLE, S_PNL_MUL and S_PNL. An entry
// stopped by a price, quantity or empty-account rule adds S_EVAL; a buy stopped on cost
// adds S_EVAL, S_MUL and S_CHECK; a matched entry adds those and S_UPDATE; a cash-limited
// buy also runs the 32-step divider in S_DIV, then S_MUL and S_CHECK again. One item at a
// time: input transfers again in the cycle after the result loads, later under output stall.
// Reset (synchronous, active low): cash 1000000.0, position zero, no order open, mark 2500.0.
module order_fill_accounting_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic        i_is_bid,
    input  logic        i_order_kind,
    input  logic [31:0] i_limit_price,
    input  logic [31:0] i_target_quantity,
    input  logic [31:0] i_entry_price,
    input  logic [31:0] i_entry_quantity,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_filled_quantity,
    output logic [62:0] o_cash_balance,
    output logic [31:0] o_position_held,
    output logic [62:0] o_profit_value,
    output logic        o_halted,
    // Configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import ofa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_PNL_MUL,
        S_PNL
    } t_state;

    t_state      r_state;

    // Account and order state.
    logic [62:0] r_cash;
    logic [31:0] r_pos;
    logic [31:0] r_rem;
    logic [31:0] r_limit;
    logic        r_side_bid;
    logic        r_is_fok;
    logic        r_stopped;
    logic [31:0] r_mark;

    // Working registers for one entry.
    logic [31:0] r_price;
    logic [31:0] r_qty;
    logic [31:0] r_q;
    logic [63:0] r_prod;
    logic [31:0] r_fill;

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_out_fill;
    logic [62:0] r_out_cash;
    logic [31:0] r_out_pos;
    logic [62:0] r_out_pnl;
    logic        r_out_halted;

    logic        in_xfer;
    logic        out_free;
    logic        out_load;
    logic [31:0] headroom;
    logic [31:0] q_min;
    logic        stop_early;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic        div_start;
    logic [31:0] div_q;
    t_div_stat   div_stat;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_PNL) && out_free;
    assign headroom = MAX32 - r_pos;

    // Candidate fill and the stop rules that need no product.
    always_comb begin
        logic [31:0] m1;
        m1 = (r_qty < r_rem) ? r_qty : r_rem;
        if (r_is_fok) begin
            q_min = r_qty;
        end else if (r_side_bid) begin
            q_min = (m1 < headroom) ? m1 : headroom;
        end else begin
            q_min = (m1 < r_pos) ? m1 : r_pos;
        end
        if (r_side_bid) begin
            stop_early = (r_limit < r_price)
                || (!r_is_fok && r_cash == '0)
                || (r_is_fok && (r_qty > r_rem || r_qty > headroom));
        end else begin
            stop_early = (r_price < r_limit) || (r_pos == '0)
                || (r_is_fok && (r_qty > r_pos || r_qty > r_rem));
        end
    end

    // Operand select for the shared multiplier.
    always_comb begin
        if (r_state == S_PNL_MUL) begin
            mul_a = r_pos;
            mul_b = r_mark;
        end else begin
            mul_a = r_q;
            mul_b = r_price;
        end
    end

    // The one 32x32 multiplier, used for the cost and for the position value.
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Cash-limited buy: quotient of cash by price.
    assign div_start = (r_state == S_CHECK) && r_side_bid && !r_is_fok
        && (r_prod > {1'b0, r_cash}) && (r_price != '0);

    ofa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cash),
        .i_divisor  (r_price),
        .o_quotient (div_q),
        .o_stat     (div_stat)
    );

    // Sequencer with account state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cash      <= CASH_RESET;
            r_pos       <= '0;
            r_rem       <= '0;
            r_limit     <= '0;
            r_side_bid  <= 1'b0;
            r_is_fok    <= 1'b0;
            r_stopped   <= 1'b1;
            r_mark      <= MARK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mark <= i_cfg_data;
            end
            // The output register fills from S_PNL and empties on a result transfer.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_price <= i_entry_price;
                        r_qty   <= i_entry_quantity;
                        r_fill  <= '0;
                        if (!i_op) begin
                            r_side_bid <= i_is_bid;
                            r_is_fok   <= i_order_kind;
                            r_limit    <= i_limit_price;
                            r_rem      <= i_target_quantity;
                            r_stopped  <= 1'b0;
                            r_state    <= S_PNL_MUL;
                        end else if (r_stopped) begin
                            r_state <= S_PNL_MUL;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    r_q <= q_min;
                    if (stop_early) begin
                        r_stopped <= 1'b1;
                        r_state   <= S_PNL_MUL;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_side_bid && r_is_fok && r_prod > {1'b0, r_cash}) begin
                        r_stopped <= 1'b1;
                        r_state   <= S_PNL_MUL;
                    end else if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_UPDATE;
                    end
                end
                S_DIV: begin
                    // Recompute the cost with the reduced fill.
                    if (div_stat.done) begin
                        r_q     <= div_q;
                        r_state <= S_MUL;
                    end
                end
                S_UPDATE: begin
                    if (r_side_bid) begin
                        r_pos  <= r_pos + r_q;
                        r_cash <= r_cash - r_prod[62:0];
                    end else begin
                        r_pos  <= r_pos - r_q;
                        r_cash <= sat_add63(r_cash, r_prod);
                    end
                    r_rem   <= r_rem - r_q;
                    r_fill  <= r_q;
                    r_state <= S_PNL_MUL;
                end
                S_PNL_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_PNL;
                end
                S_PNL: begin
                    if (out_free) begin
                        r_out_fill   <= r_fill;
                        r_out_cash   <= r_cash;
                        r_out_pos    <= r_pos;
                        r_out_pnl    <= sat_add63(r_cash, r_prod);
                        r_out_halted <= r_stopped;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_filled_quantity = r_out_fill;
    assign o_cash_balance    = r_out_cash;
    assign o_position_held   = r_out_pos;
    assign o_profit_value    = r_out_pnl;
    assign o_halted          = r_out_halted;
    assign o_cfg_ready       = 1'b1;

endmodule

[hdl/ofa_checker.sv]
module ofa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_filled_quantity,
    input logic [62:0] o_cash_balance,
    input logic [62:0] o_profit_value,
    input logic        o_halted
);

    // A result waiting on a stalled consumer stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // Each accepted item occupies the sequencer for at least the next cycle.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // A stopped order never reports a fill.
    a_halt_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_halted) |-> (o_filled_quantity == '0))
        else $error("fill reported on a halted order");

    // The marked value includes the cash and only adds a nonnegative position value.
    a_pnl_ge_cash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_profit_value >= o_cash_balance))
        else $error("pnl below cash balance");

endmodule

bind order_fill_accounting_unit ofa_checker u_ofa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_filled_quantity (o_filled_quantity),
    .o_cash_balance    (o_cash_balance),
    .o_profit_value    (o_profit_value),
    .o_halted          (o_halted)
);

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import ofa_pkg::*;

    // Item codes and order attributes.
    localparam logic OP_BEGIN  = 1'b0;
    localparam logic OP_ENTRY  = 1'b1;
    localparam logic SIDE_SELL = 1'b0;
    localparam logic SIDE_BUY  = 1'b1;
    localparam logic KIND_IOC  = 1'b0;
    localparam logic KIND_FOK  = 1'b1;

    // Cycles without any transfer before the run is declared hung.
    localparam int unsigned QUIET_LIMIT = 4000;
    // Settling time after the last result, above the divider latency.
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned PHASE_ITEMS = 305;
    localparam int unsigned MAX_REPORTS = 25;

    typedef struct packed {
        logic        op;
        logic        is_bid;
        logic        kind;
        logic [31:0] limit;
        logic [31:0] target;
        logic [31:0] eprice;
        logic [31:0] eqty;
    } t_order_item;

    typedef struct packed {
        logic [31:0] fill;
        logic [62:0] cash;
        logic [31:0] pos;
        logic [62:0] pnl;
        logic        halted;
    } t_fill_report;

    typedef struct packed {
        t_order_item  item;
        logic         typed;
        t_fill_report want;
    } t_book_row;

    localparam t_fill_report NO_REPORT = '0;

    // Clock, reset and block inputs, all known from time zero.
    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic        i_op              = 1'b0;
    logic        i_is_bid          = 1'b0;
    logic        i_order_kind      = 1'b0;
    logic [31:0] i_limit_price     = '0;
    logic [31:0] i_target_quantity = '0;
    logic [31:0] i_entry_price     = '0;
    logic [31:0] i_entry_quantity  = '0;
    logic        i_out_stall       = 1'b0;
    logic        i_cfg_valid       = 1'b0;
    logic [31:0] i_cfg_data        = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_filled_quantity;
    logic [62:0] o_cash_balance;
    logic [31:0] o_position_held;
    logic [62:0] o_profit_value;
    logic        o_halted;
    logic        o_cfg_ready;

    // Typed expectation that travels with the payload of a directed row.
    logic         row_typed  = 1'b0;
    t_fill_report row_expect = '0;

    // Predicted state of the accounting unit.
    logic [31:0] mark_px;
    logic [62:0] cash_bal;
    logic [31:0] pos_held;
    logic [31:0] qty_left;
    logic [31:0] ord_limit;
    logic        ord_buy;
    logic        ord_fok;
    logic        ord_stopped;

    t_fill_report pending_reports[$];
    t_book_row    dir_rows[31];

    int unsigned fail_count     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned items_sent     = 0;
    int unsigned phase_items    = 0;
    int unsigned orders_opened  = 0;
    int unsigned entries_seen   = 0;
    int unsigned fills_taken    = 0;
    int unsigned halted_entries = 0;
    int unsigned mark_settings  = 1;
    int unsigned stall_run      = 0;
    bit          no_gaps        = 1'b0;

    order_fill_accounting_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_is_bid          (i_is_bid),
        .i_order_kind      (i_order_kind),
        .i_limit_price     (i_limit_price),
        .i_target_quantity (i_target_quantity),
        .i_entry_price     (i_entry_price),
        .i_entry_quantity  (i_entry_quantity),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_filled_quantity (o_filled_quantity),
        .o_cash_balance    (o_cash_balance),
        .o_position_held   (o_position_held),
        .o_profit_value    (o_profit_value),
        .o_halted          (o_halted),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cash addition that clamps at the largest 63-bit value.
    function automatic logic [62:0] add_saturated(input logic [62:0] base, input logic [63:0] inc);
        logic [63:0] room;
        room = {1'b0, MAX63 - base};
        if (inc > room) begin
            return MAX63;
        end
        return base + inc[62:0];
    endfunction

    // Apply one item to the predicted book state and return the report it produces.
    function automatic t_fill_report predict_fill(input t_order_item it);
        t_fill_report r;
        logic [63:0]  q;
        logic [63:0]  px;
        logic [63:0]  lot;
        logic [63:0]  cost;
        logic [63:0]  room;
        q   = '0;
        px  = {32'd0, it.eprice};
        lot = {32'd0, it.eqty};
        if (it.op == OP_BEGIN) begin
            ord_buy     = (it.is_bid == SIDE_BUY);
            ord_fok     = (it.kind == KIND_FOK);
            ord_limit   = it.limit;
            qty_left    = it.target;
            ord_stopped = 1'b0;
        end else if (!ord_stopped) begin
            if (ord_buy) begin
                room = {32'd0, MAX32 - pos_held};
                if (ord_limit < it.eprice) begin
                    ord_stopped = 1'b1;
                end else if (ord_fok) begin
                    cost = lot * px;
                    if (cost > {1'b0, cash_bal} || it.eqty > qty_left || lot > room) begin
                        ord_stopped = 1'b1;
                    end else begin
                        q = lot;
                    end
                end else if (cash_bal == '0) begin
                    ord_stopped = 1'b1;
                end else begin
                    q = lot;
                    if ({32'd0, qty_left} < q) q = {32'd0, qty_left};
                    if (room < q) q = room;
                    // Spend no more than the cash on hand.
                    if (px != '0 && q * px > {1'b0, cash_bal}) q = {1'b0, cash_bal} / px;
                end
                cost     = q * px;
                pos_held = pos_held + q[31:0];
                cash_bal = cash_bal - cost[62:0];
                qty_left = qty_left - q[31:0];
            end else begin
                if (it.eprice < ord_limit || pos_held == '0) begin
                    ord_stopped = 1'b1;
                end else if (ord_fok) begin
                    if (it.eqty > pos_held || it.eqty > qty_left) begin
                        ord_stopped = 1'b1;
                    end else begin
                        q = lot;
                    end
                end else begin
                    q = lot;
                    if ({32'd0, qty_left} < q) q = {32'd0, qty_left};
                    if ({32'd0, pos_held} < q) q = {32'd0, pos_held};
                end
                cash_bal = add_saturated(cash_bal, q * px);
                pos_held = pos_held - q[31:0];
                qty_left = qty_left - q[31:0];
            end
        end
        r.fill   = q[31:0];
        r.cash   = cash_bal;
        r.pos    = pos_held;
        r.pnl    = add_saturated(cash_bal, {32'd0, pos_held} * {32'd0, mark_px});
        r.halted = ord_stopped;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (fail_count < MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            end
            fail_count++;
        end
    endtask

    // Prediction on each input transfer, checking on each result transfer.
    always @(posedge i_clk) begin : scoreboard
        t_order_item  it;
        t_fill_report pred;
        t_fill_report want;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                mark_px = i_cfg_data;
                moved   = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                it.op     = i_op;
                it.is_bid = i_is_bid;
                it.kind   = i_order_kind;
                it.limit  = i_limit_price;
                it.target = i_target_quantity;
                it.eprice = i_entry_price;
                it.eqty   = i_entry_quantity;
                pred = predict_fill(it);
                if (it.op == OP_BEGIN) begin
                    orders_opened++;
                end else begin
                    entries_seen++;
                    if (pred.fill != '0) fills_taken++;
                    if (pred.halted) halted_entries++;
                end
                pending_reports.insert(pending_reports.size(), row_typed ? row_expect : pred);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (pending_reports.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("%0t: result transfer with no expectation waiting", $time);
                    end
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("filled_quantity", {32'd0, want.fill}, {32'd0, o_filled_quantity});
                    check_field("cash_balance", {1'b0, want.cash}, {1'b0, o_cash_balance});
                    check_field("position_held", {32'd0, want.pos}, {32'd0, o_position_held});
                    check_field("profit_value", {1'b0, want.pnl}, {1'b0, o_profit_value});
                    check_field("halted", {63'd0, want.halted}, {63'd0, o_halted});
                end
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    // Result-side back-pressure: mostly short stalls, some long ones, and quiet stretches.
    always @(posedge i_clk) begin : out_stall_gen
        int unsigned roll;
        if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                i_out_stall <= 1'b1;
                stall_run   <= (roll < 25) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end else begin
                i_out_stall <= 1'b0;
                stall_run   <= (roll < 90) ? $urandom_range(0, 4) : $urandom_range(50, 200);
            end
        end
    end

    // A hung block ends the run.
    initial begin : watchdog
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL order_fill_accounting_unit");
        $finish;
    end

    function automatic int unsigned next_gap();
        int unsigned roll;
        if (no_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item and hold it until the input transfer happens.
    task automatic send_item(input t_order_item it, input logic typed, input t_fill_report want);
        int unsigned gap;
        i_in_valid        <= 1'b1;
        i_op              <= it.op;
        i_is_bid          <= it.is_bid;
        i_order_kind      <= it.kind;
        i_limit_price     <= it.limit;
        i_target_quantity <= it.target;
        i_entry_price     <= it.eprice;
        i_entry_quantity  <= it.eqty;
        row_typed         <= typed;
        row_expect        <= want;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        phase_items++;
        gap = next_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the input until every expected result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic write_mark(input logic [31:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mark_settings++;
    endtask

    function automatic logic [31:0] pick_lot();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 15) return $urandom_range(1, 255);
        return $urandom_range(256, 256 * 60);
    endfunction

    // One random order: a begin followed by book entries in priority order.
    // A few are large-value orders that drain or flood cash, and a few are pure noise.
    task automatic send_order_burst();
        t_order_item it;
        logic [31:0] px;
        int unsigned n;
        int unsigned roll;
        logic        buy;
        bit          whale;
        roll    = $urandom_range(0, 99);
        no_gaps = ($urandom_range(0, 3) == 0);
        it.op     = 1'($urandom_range(0, 1));
        it.is_bid = 1'($urandom_range(0, 1));
        it.kind   = 1'($urandom_range(0, 1));
        it.limit  = $urandom;
        it.target = $urandom;
        it.eprice = $urandom;
        it.eqty   = $urandom;
        if (roll < 8) begin
            send_item(it, 1'b0, NO_REPORT);
        end else begin
            whale  = (roll < 16);
            buy    = 1'($urandom_range(0, 1));
            px     = 256 * $urandom_range(50, 150) + $urandom_range(0, 255);
            it.op     = OP_BEGIN;
            it.is_bid = buy;
            if (whale) begin
                it.limit = (buy == SIDE_BUY) ? MAX32 : '0;
            end else begin
                it.limit  = (buy == SIDE_BUY) ? px + $urandom_range(0, 5120)
                                              : px - $urandom_range(0, 5120);
                it.target = $urandom_range(1, 256 * 300);
            end
            send_item(it, 1'b0, NO_REPORT);
            n = $urandom_range(1, 8);
            repeat (n) begin
                it.op     = OP_ENTRY;
                it.is_bid = 1'($urandom_range(0, 1));
                it.kind   = 1'($urandom_range(0, 1));
                it.limit  = $urandom;
                it.target = $urandom;
                if (whale) begin
                    it.eprice = $urandom;
                    it.eqty   = $urandom;
                end else begin
                    it.eprice = px;
                    it.eqty   = pick_lot();
                    px = (buy == SIDE_BUY) ? px + $urandom_range(0, 640)
                                           : px - $urandom_range(0, 640);
                end
                send_item(it, 1'b0, NO_REPORT);
            end
        end
    endtask

    initial begin : main
        logic [31:0] mark_plan[5];

        // Reset state of the prediction.
        mark_px     = MARK_RESET;
        cash_bal    = CASH_RESET;
        pos_held    = '0;
        qty_left    = '0;
        ord_limit   = '0;
        ord_buy     = 1'b0;
        ord_fok     = 1'b0;
        ord_stopped = 1'b1;

        // Directed rows: entry fields are zero on begins and order fields on entries.
        dir_rows = '{
            // Entry with no open order is ignored.
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd25600, 32'd1024}, 1'b1,
              '{32'd0, CASH_RESET, 32'd0, CASH_RESET, 1'b1}},
            '{'{OP_BEGIN, SIDE_BUY, KIND_IOC, MAX32, 32'd2560, 32'd0, 32'd0}, 1'b1,
              '{32'd0, CASH_RESET, 32'd0, CASH_RESET, 1'b0}},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd25600, 32'd4096}, 1'b1,
              '{32'd2560, 63'd65470464000, 32'd2560, 63'd67108864000, 1'b0}},
            // Target reached: fills of zero, order still live.
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd25700, 32'd512}, 1'b0, NO_REPORT},
            // Price above the buy limit stops the order; the next entry is ignored.
            '{'{OP_BEGIN, SIDE_BUY, KIND_IOC, 32'd12800, MAX32, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd12801, 32'd256}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd100, 32'd256}, 1'b0, NO_REPORT},
            // Zero price, cash-limited division, then clipping at the position ceiling.
            '{'{OP_BEGIN, SIDE_BUY, KIND_IOC, MAX32, MAX32, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd0, 32'd1000}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, MAX32, MAX32}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd0, MAX32}, 1'b0, NO_REPORT},
            // Fill-or-kill buy with no position headroom left.
            '{'{OP_BEGIN, SIDE_BUY, KIND_FOK, MAX32, MAX32, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd0, 32'd1}, 1'b0, NO_REPORT},
            // Selling the full position at the top price saturates cash and pnl.
            '{'{OP_BEGIN, SIDE_SELL, KIND_IOC, 32'd0, MAX32, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, MAX32, MAX32}, 1'b1,
              '{MAX32, MAX63, 32'd0, MAX63, 1'b0}},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd25600, 32'd256}, 1'b1,
              '{32'd0, MAX63, 32'd0, MAX63, 1'b1}},
            // Fill-or-kill buy: one whole entry, then one larger than what is left.
            '{'{OP_BEGIN, SIDE_BUY, KIND_FOK, 32'd25600, 32'd2560, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd25600, 32'd1024}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd25600, 32'd2048}, 1'b0, NO_REPORT},
            // Fill-or-kill buy that costs more than the cash on hand.
            '{'{OP_BEGIN, SIDE_BUY, KIND_FOK, MAX32, MAX32, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, MAX32, MAX32}, 1'b0, NO_REPORT},
            // Fill-or-kill sell: one fill, then an entry above what is left.
            '{'{OP_BEGIN, SIDE_SELL, KIND_FOK, 32'd25600, 32'd768, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd30000, 32'd512}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd29000, 32'd512}, 1'b0, NO_REPORT},
            // Fill-or-kill sell larger than the position.
            '{'{OP_BEGIN, SIDE_SELL, KIND_FOK, 32'd0, MAX32, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd100, 32'd1024}, 1'b0, NO_REPORT},
            // Price below the sell limit stops the order.
            '{'{OP_BEGIN, SIDE_SELL, KIND_IOC, 32'd25600, MAX32, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd25599, 32'd256}, 1'b0, NO_REPORT},
            // A second begin replaces the open order.
            '{'{OP_BEGIN, SIDE_SELL, KIND_IOC, 32'd0, 32'd100, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_BEGIN, SIDE_SELL, KIND_IOC, 32'd0, 32'd200, 32'd0, 32'd0}, 1'b0, NO_REPORT},
            '{'{OP_ENTRY, SIDE_SELL, KIND_IOC, 32'd0, 32'd0, 32'd256, 32'd1000}, 1'b0, NO_REPORT}
        };

        mark_plan[0] = MAX32;
        mark_plan[1] = '0;
        mark_plan[2] = $urandom;
        mark_plan[3] = MARK_RESET;
        mark_plan[4] = $urandom_range(1, 256 * 5000);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset mark price.
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random part, one mark price setting per phase.
        foreach (mark_plan[p]) begin
            write_mark(mark_plan[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                send_order_burst();
                if ($urandom_range(0, 39) == 0) drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items: %0d orders and %0d book entries, %0d of them filled,",
                 items_sent, orders_opened, entries_seen, fills_taken);
        $display("%0d reported halted, across %0d mark price settings.",
                 halted_entries, mark_settings);
        if (fail_count == 0) begin
            $display("PASS order_fill_accounting_unit");
        end else begin
            $display("FAIL order_fill_accounting_unit");
        end
        $finish;
    end

endmodule

[order_fill_accounting_unit.f]
hdl/ofa_pkg.sv
hdl/ofa_div.sv
hdl/order_fill_accounting_unit.sv
hdl/ofa_checker.sv
test/tb_top.sv
